@@ src/dpbp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpbp_pkg
// Widths, constants, shared types and the saturation helper of the depth
// pixel back-projection datapath.
// ----------------------------------------------------------------------------
package dpbp_pkg;

    // Field widths of the pixel and point channels.
    localparam int DEPTH_W    = 16;
    localparam int COORD_W    = 12;
    localparam int POINT_W    = 32;

    // Configuration field widths.
    localparam int FRAME_W    = 16;
    localparam int K_W        = 31;
    localparam int PP_W       = 28;
    localparam int PP_FRAC    = 16;
    localparam int DSCALE_W   = 32;
    localparam int COEF_W     = 20;
    localparam int TRANS_W    = 21;
    localparam int CFG_DATA_W = 63;
    localparam int CFG_IDX_W  = 3;

    // Pinhole projection datapath widths.
    localparam int OFF_W      = PP_W + 1;
    localparam int MAG_W      = PP_W;
    localparam int AMUL_W     = MAG_W + DEPTH_W;
    localparam int K_SPLIT    = 16;
    localparam int KHI_W      = K_W - K_SPLIT;
    localparam int HI_W       = AMUL_W + KHI_W;
    localparam int LO_W       = AMUL_W + K_SPLIT;
    localparam int PROJ_W     = AMUL_W + K_W + 1;
    localparam int PROJ_SHIFT = 40;
    localparam int Q_W        = PROJ_W - PROJ_SHIFT;
    localparam int ZPROD_W    = DEPTH_W + DSCALE_W;
    localparam int Z_SHIFT    = 24;
    localparam int ZQ_W       = ZPROD_W - Z_SHIFT;

    // Rotation datapath widths.
    localparam int PROD_W     = COEF_W + POINT_W;
    localparam int SUM_W      = PROD_W + 2;
    localparam int ROT_SHIFT  = 18;
    localparam int RQ_W       = SUM_W - ROT_SHIFT;

    // Saturation helper input width.
    localparam int SAT_W      = 40;

    localparam logic [DEPTH_W-1:0] INVALID_DEPTH = 16'd4096;
    localparam logic [32:0]        FRAME_RESET   = 33'd31457920;

    localparam logic [SAT_W-1:0]   NEG_LIMIT = 40'h0080000000;
    localparam logic [SAT_W-1:0]   POS_LIMIT = 40'h007FFFFFFF;
    localparam logic signed [POINT_W-1:0] POINT_MAX = 32'sh7FFFFFFF;
    localparam logic signed [POINT_W-1:0] POINT_MIN = 32'sh80000000;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_AND_MODE  = 3'd0,
        REG_FOCAL_INVERSE   = 3'd1,
        REG_PRINCIPAL_POINT = 3'd2,
        REG_DEPTH_SCALE     = 3'd3,
        REG_ROTATION_ROW_X  = 3'd4,
        REG_ROTATION_ROW_Y  = 3'd5,
        REG_ROTATION_ROW_Z  = 3'd6,
        REG_TRANSLATION     = 3'd7
    } cfg_reg_t;

    // Camera intrinsics and frame geometry.
    typedef struct packed {
        logic [FRAME_W-1:0]  width;
        logic [FRAME_W-1:0]  height;
        logic [K_W-1:0]      kx;
        logic [K_W-1:0]      ky;
        logic [PP_W-1:0]     cx;
        logic [PP_W-1:0]     cy;
        logic [DSCALE_W-1:0] depth_scale;
    } intr_cfg_t;

    // Rigid transform: rot[r][c] is the coefficient of input c for output r.
    typedef struct packed {
        logic                              enable;
        logic [2:0][2:0][COEF_W-1:0]       rot;
        logic [2:0][TRANS_W-1:0]           trans;
    } xform_cfg_t;

    // Validated pixel in sign-magnitude offset form.
    typedef struct packed {
        logic               pix_ok;
        logic               neg_x;
        logic               neg_y;
        logic [MAG_W-1:0]   mag_x;
        logic [MAG_W-1:0]   mag_y;
        logic [DEPTH_W-1:0] depth;
    } front_t;

    // Camera-frame point.
    typedef struct packed {
        logic                      ok;
        logic signed [POINT_W-1:0] x;
        logic signed [POINT_W-1:0] y;
        logic signed [POINT_W-1:0] z;
    } point_t;

    // Apply a sign to a magnitude and clamp to the signed 32-bit range.
    function automatic logic signed [POINT_W-1:0] sat_mag(input logic neg,
                                                          input logic [SAT_W-1:0] mag);
        logic [SAT_W-1:0]          neg_mag;
        logic signed [POINT_W-1:0] res;
        neg_mag = SAT_W'(0) - mag;
        if (neg) begin
            if (mag >= NEG_LIMIT) res = POINT_MIN;
            else                  res = neg_mag[POINT_W-1:0];
        end else begin
            if (mag > POS_LIMIT)  res = POINT_MAX;
            else                  res = mag[POINT_W-1:0];
        end
        return res;
    endfunction

endpackage

@@ src/depth_pixel_back_projection.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_pixel_back_projection
// Turns a depth pixel with its column and row into a 3-D point in signed
// Q15.16 metres through a pinhole model, with an optional rotation and
// translation.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock while the output side does not stall
// and returns one point per pixel, in order. The seven-stage pipeline is:
// validation and offset forming, offset times depth, split focal-scale
// products, rounding and saturation, nine rotation products, row sums with
// translation, and final rounding into the output register. Each stage holds
// its item while the next one is full, so back-pressure on the result side
// stalls the pipeline without losing or repeating a transfer. Pixels with a
// depth of 0 or 4096, or within BORDER_PIXELS of a frame edge, give
// point_valid low and zero coordinates. Configuration registers are written
// through cfg_wr_en, cfg_index and cfg_wdata and must only change while no
// pixel is in flight.
// ----------------------------------------------------------------------------
module depth_pixel_back_projection
    import dpbp_pkg::*;
#(
    parameter int BORDER_PIXELS = 50,
    parameter int COORD_BITS    = 12
) (
    input  logic                      aclk,
    input  logic                      aresetn,

    input  logic                      cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_wdata,

    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [DEPTH_W-1:0]        s_depth,
    input  logic [COORD_W-1:0]        s_column,
    input  logic [COORD_W-1:0]        s_row,

    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_point_valid,
    output logic signed [POINT_W-1:0] m_point_x,
    output logic signed [POINT_W-1:0] m_point_y,
    output logic signed [POINT_W-1:0] m_point_z
);

    logic [32:0]  frame_and_mode_reg;
    logic [61:0]  focal_inverse_reg;
    logic [55:0]  principal_point_reg;
    logic [31:0]  depth_scale_reg;
    logic [59:0]  rotation_row_x_reg;
    logic [59:0]  rotation_row_y_reg;
    logic [59:0]  rotation_row_z_reg;
    logic [62:0]  translation_reg;

    intr_cfg_t    intr_cfg;
    xform_cfg_t   xform_cfg;

    logic         front_valid, front_ready;
    front_t       front_data;
    logic         proj_valid, proj_ready;
    point_t       proj_data;
    point_t       out_pt;

    // Configuration register file.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_and_mode_reg  <= FRAME_RESET;
            focal_inverse_reg   <= '0;
            principal_point_reg <= '0;
            depth_scale_reg     <= '0;
            rotation_row_x_reg  <= '0;
            rotation_row_y_reg  <= '0;
            rotation_row_z_reg  <= '0;
            translation_reg     <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FRAME_AND_MODE:  frame_and_mode_reg  <= cfg_wdata[32:0];
                REG_FOCAL_INVERSE:   focal_inverse_reg   <= cfg_wdata[61:0];
                REG_PRINCIPAL_POINT: principal_point_reg <= cfg_wdata[55:0];
                REG_DEPTH_SCALE:     depth_scale_reg     <= cfg_wdata[31:0];
                REG_ROTATION_ROW_X:  rotation_row_x_reg  <= cfg_wdata[59:0];
                REG_ROTATION_ROW_Y:  rotation_row_y_reg  <= cfg_wdata[59:0];
                REG_ROTATION_ROW_Z:  rotation_row_z_reg  <= cfg_wdata[59:0];
                REG_TRANSLATION:     translation_reg     <= cfg_wdata[62:0];
            endcase
        end
    end

    // Field views of the registers for the datapath.
    always_comb begin
        intr_cfg.width       = frame_and_mode_reg[15:0];
        intr_cfg.height      = frame_and_mode_reg[31:16];
        intr_cfg.kx          = focal_inverse_reg[30:0];
        intr_cfg.ky          = focal_inverse_reg[61:31];
        intr_cfg.cx          = principal_point_reg[27:0];
        intr_cfg.cy          = principal_point_reg[55:28];
        intr_cfg.depth_scale = depth_scale_reg;
        xform_cfg.enable     = frame_and_mode_reg[32];
        xform_cfg.rot        = {rotation_row_z_reg, rotation_row_y_reg, rotation_row_x_reg};
        xform_cfg.trans      = translation_reg;
    end

    dpbp_front #(
        .BORDER_PIXELS (BORDER_PIXELS),
        .COORD_BITS    (COORD_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (intr_cfg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .depth     (s_depth),
        .column    (s_column),
        .row       (s_row),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_data  (front_data)
    );

    dpbp_project u_project (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (intr_cfg),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_data),
        .out_valid (proj_valid),
        .out_ready (proj_ready),
        .out_data  (proj_data)
    );

    dpbp_rotate u_rotate (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (xform_cfg),
        .in_valid  (proj_valid),
        .in_ready  (proj_ready),
        .in_data   (proj_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_pt)
    );

    assign m_point_valid = out_pt.ok;
    assign m_point_x     = out_pt.x;
    assign m_point_y     = out_pt.y;
    assign m_point_z     = out_pt.z;

endmodule

@@ src/dpbp_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpbp_front
// First pipeline stage: validates depth and border, forms the pixel offsets
// from the principal point in sign-magnitude form.
// ----------------------------------------------------------------------------
module dpbp_front
    import dpbp_pkg::*;
#(
    parameter int BORDER_PIXELS = 50,
    parameter int COORD_BITS    = 12
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  intr_cfg_t          cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [DEPTH_W-1:0] depth,
    input  logic [COORD_W-1:0] column,
    input  logic [COORD_W-1:0] row,
    output logic               out_valid,
    input  logic               out_ready,
    output front_t             out_data
);

    localparam int USED_BITS = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
    localparam logic [COORD_W-1:0] COORD_MASK = {COORD_W{1'b1}} >> (COORD_W - USED_BITS);
    localparam int EXT_W = FRAME_W + 1;
    localparam logic [EXT_W-1:0] BORDER = EXT_W'(BORDER_PIXELS);

    logic               v_reg;
    front_t             data_reg;
    front_t             data_next;
    logic [COORD_W-1:0] col_q;
    logic [COORD_W-1:0] row_q;
    logic [EXT_W-1:0]   col_e;
    logic [EXT_W-1:0]   row_e;
    logic               depth_bad;
    logic               border_bad;
    logic [OFF_W-1:0]   diff_x;
    logic [OFF_W-1:0]   diff_y;
    logic [OFF_W-1:0]   ndiff_x;
    logic [OFF_W-1:0]   ndiff_y;

    assign in_ready  = !v_reg || out_ready;
    assign out_valid = v_reg;
    assign out_data  = data_reg;

    // Pixel validity: reserved depth codes and the frame border.
    always_comb begin
        col_q      = column & COORD_MASK;
        row_q      = row & COORD_MASK;
        col_e      = EXT_W'(col_q);
        row_e      = EXT_W'(row_q);
        depth_bad  = (depth == '0) || (depth == INVALID_DEPTH);
        border_bad = (col_e < BORDER) || (row_e < BORDER)
                  || ((col_e + BORDER) >= EXT_W'(cfg.width))
                  || ((row_e + BORDER) >= EXT_W'(cfg.height));
    end

    // Offsets from the principal point, in Q12.16 pixels.
    always_comb begin
        diff_x  = {1'b0, col_q, {PP_FRAC{1'b0}}} - {1'b0, cfg.cx};
        diff_y  = {1'b0, row_q, {PP_FRAC{1'b0}}} - {1'b0, cfg.cy};
        ndiff_x = OFF_W'(0) - diff_x;
        ndiff_y = OFF_W'(0) - diff_y;
        data_next.pix_ok = !depth_bad && !border_bad;
        data_next.neg_x  = diff_x[OFF_W-1];
        data_next.neg_y  = diff_y[OFF_W-1];
        data_next.mag_x  = diff_x[OFF_W-1] ? ndiff_x[MAG_W-1:0] : diff_x[MAG_W-1:0];
        data_next.mag_y  = diff_y[OFF_W-1] ? ndiff_y[MAG_W-1:0] : diff_y[MAG_W-1:0];
        data_next.depth  = depth;
    end

    // Stage register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (in_ready) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

@@ src/dpbp_project.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpbp_project
// Three pipeline stages of the pinhole back-projection: offset times depth,
// split products with the inverse focal scales, then rounding and saturation.
// ----------------------------------------------------------------------------
module dpbp_project
    import dpbp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  intr_cfg_t cfg,
    input  logic      in_valid,
    output logic      in_ready,
    input  front_t    in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output point_t    out_data
);

    localparam logic [ZPROD_W-1:0] Z_RND    = ZPROD_W'(1) << (Z_SHIFT - 1);
    localparam logic [PROJ_W-1:0]  PROJ_RND = PROJ_W'(1) << (PROJ_SHIFT - 1);

    logic rdy2, rdy3, rdy4;
    logic v2_reg, v3_reg, v4_reg;

    // Stage 2 payload.
    logic                ok2_reg, negx2_reg, negy2_reg;
    logic [AMUL_W-1:0]   ax2_reg, ay2_reg;
    logic [ZPROD_W-1:0]  zp2_reg;

    // Stage 3 payload.
    logic                ok3_reg, negx3_reg, negy3_reg;
    logic [HI_W-1:0]     hx3_reg, hy3_reg;
    logic [LO_W-1:0]     lx3_reg, ly3_reg;
    logic [ZQ_W-1:0]     zq3_reg;
    logic [ZPROD_W-1:0]  zsum;

    // Stage 4 payload.
    point_t              pt4_reg;
    point_t              pt4_next;
    logic [PROJ_W-1:0]   sum_x, sum_y;

    assign rdy2      = !v2_reg || rdy3;
    assign rdy3      = !v3_reg || rdy4;
    assign rdy4      = !v4_reg || out_ready;
    assign in_ready  = rdy2;
    assign out_valid = v4_reg;
    assign out_data  = pt4_reg;

    // Valid bits move with the data; a stage loads when it is empty or drains.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy2) v2_reg <= in_valid;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    // Stage 2: offset magnitude times depth, depth times depth scale.
    always_ff @(posedge aclk) begin
        if (rdy2 && in_valid) begin
            ok2_reg   <= in_data.pix_ok;
            negx2_reg <= in_data.neg_x;
            negy2_reg <= in_data.neg_y;
            ax2_reg   <= AMUL_W'(in_data.mag_x) * AMUL_W'(in_data.depth);
            ay2_reg   <= AMUL_W'(in_data.mag_y) * AMUL_W'(in_data.depth);
            zp2_reg   <= ZPROD_W'(in_data.depth) * ZPROD_W'(cfg.depth_scale);
        end
    end

    // Stage 3: products with the high and low halves of each focal scale, and the rounded z.
    assign zsum = zp2_reg + Z_RND;

    always_ff @(posedge aclk) begin
        if (rdy3 && v2_reg) begin
            ok3_reg   <= ok2_reg;
            negx3_reg <= negx2_reg;
            negy3_reg <= negy2_reg;
            hx3_reg   <= HI_W'(ax2_reg) * HI_W'(cfg.kx[K_W-1:K_SPLIT]);
            lx3_reg   <= LO_W'(ax2_reg) * LO_W'(cfg.kx[K_SPLIT-1:0]);
            hy3_reg   <= HI_W'(ay2_reg) * HI_W'(cfg.ky[K_W-1:K_SPLIT]);
            ly3_reg   <= LO_W'(ay2_reg) * LO_W'(cfg.ky[K_SPLIT-1:0]);
            zq3_reg   <= zsum[ZPROD_W-1:Z_SHIFT];
        end
    end

    // Stage 4: recombine, round half away from zero, saturate.
    always_comb begin
        sum_x = (PROJ_W'(hx3_reg) << K_SPLIT) + PROJ_W'(lx3_reg) + PROJ_RND;
        sum_y = (PROJ_W'(hy3_reg) << K_SPLIT) + PROJ_W'(ly3_reg) + PROJ_RND;
        pt4_next.ok = ok3_reg;
        pt4_next.x  = sat_mag(negx3_reg, SAT_W'(sum_x[PROJ_W-1:PROJ_SHIFT]));
        pt4_next.y  = sat_mag(negy3_reg, SAT_W'(sum_y[PROJ_W-1:PROJ_SHIFT]));
        pt4_next.z  = POINT_W'(zq3_reg);
    end

    always_ff @(posedge aclk) begin
        if (rdy4 && v3_reg) begin
            pt4_reg <= pt4_next;
        end
    end

endmodule

@@ src/dpbp_rotate.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpbp_rotate
// Three pipeline stages of the rigid transform: nine coefficient products,
// row sums with translation, then rounding, saturation and output select.
// The last stage is the output register of the block.
// ----------------------------------------------------------------------------
module dpbp_rotate
    import dpbp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  xform_cfg_t cfg,
    input  logic       in_valid,
    output logic       in_ready,
    input  point_t     in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output point_t     out_data
);

    localparam logic [SUM_W-1:0] ROT_RND = SUM_W'(1) << (ROT_SHIFT - 1);

    logic rdy5, rdy6, rdy7;
    logic v5_reg, v6_reg, v7_reg;

    // Stage 5 payload.
    point_t                    pt5_reg;
    logic signed [PROD_W-1:0]  prod5_reg [3][3];
    logic signed [PROD_W-1:0]  prod5_next [3][3];
    logic signed [POINT_W-1:0] pin [3];

    // Stage 6 payload.
    point_t                    pt6_reg;
    logic signed [SUM_W-1:0]   sum6_reg [3];
    logic signed [SUM_W-1:0]   sum6_next [3];

    // Stage 7 payload.
    point_t                    pt7_reg;
    point_t                    pt7_next;
    logic signed [POINT_W-1:0] rot7 [3];

    assign rdy5      = !v5_reg || rdy6;
    assign rdy6      = !v6_reg || rdy7;
    assign rdy7      = !v7_reg || out_ready;
    assign in_ready  = rdy5;
    assign out_valid = v7_reg;
    assign out_data  = pt7_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end else begin
            if (rdy5) v5_reg <= in_valid;
            if (rdy6) v6_reg <= v5_reg;
            if (rdy7) v7_reg <= v6_reg;
        end
    end

    // Stage 5: each coefficient times its input coordinate.
    always_comb begin
        logic signed [COEF_W-1:0] coef;
        pin[0] = in_data.x;
        pin[1] = in_data.y;
        pin[2] = in_data.z;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                coef = cfg.rot[r][c];
                prod5_next[r][c] = PROD_W'(coef) * PROD_W'(pin[c]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy5 && in_valid) begin
            pt5_reg   <= in_data;
            prod5_reg <= prod5_next;
        end
    end

    // Stage 6: row sums plus translation, all in Q.34.
    always_comb begin
        logic signed [TRANS_W-1:0] t;
        logic signed [SUM_W-1:0]   acc;
        logic signed [SUM_W-1:0]   t_ext;
        for (int r = 0; r < 3; r++) begin
            t     = cfg.trans[r];
            t_ext = SUM_W'(t);
            acc   = SUM_W'(prod5_reg[r][0]);
            acc   = acc + SUM_W'(prod5_reg[r][1]);
            acc   = acc + SUM_W'(prod5_reg[r][2]);
            sum6_next[r] = acc + (t_ext <<< ROT_SHIFT);
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy6 && v5_reg) begin
            pt6_reg  <= pt5_reg;
            sum6_reg <= sum6_next;
        end
    end

    // Stage 7: round to Q.16 half away from zero, saturate, select the result.
    always_comb begin
        logic             neg;
        logic [SUM_W-1:0] mag;
        logic [SUM_W-1:0] rnd;
        for (int r = 0; r < 3; r++) begin
            neg     = sum6_reg[r][SUM_W-1];
            mag     = neg ? (SUM_W'(0) - sum6_reg[r]) : sum6_reg[r];
            rnd     = mag + ROT_RND;
            rot7[r] = sat_mag(neg, SAT_W'(rnd[SUM_W-1:ROT_SHIFT]));
        end
        pt7_next.ok = pt6_reg.ok;
        if (!pt6_reg.ok) begin
            pt7_next.x = '0;
            pt7_next.y = '0;
            pt7_next.z = '0;
        end else if (cfg.enable) begin
            pt7_next.x = rot7[0];
            pt7_next.y = rot7[1];
            pt7_next.z = rot7[2];
        end else begin
            pt7_next.x = pt6_reg.x;
            pt7_next.y = pt6_reg.y;
            pt7_next.z = pt6_reg.z;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy7 && v6_reg) begin
            pt7_reg <= pt7_next;
        end
    end

endmodule
